// ===== src/rmp_pkg.sv =====
// Package for the 2x2 RGB max pooling core: sizes, the pixel word type,
// the scan position struct and the per-channel maximum function.
// No dependencies; used by every module in src.
package rmp_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE   = 2;

    localparam int SIZE_W  = 13;                       // configuration register width
    localparam int COL_W   = $clog2(MAX_WIDTH);        // column counter width
    localparam int ROW_W   = $clog2(MAX_HEIGHT);       // row counter width
    localparam int WDIM_W  = COL_W + 1;                // holds MAX_WIDTH itself
    localparam int HDIM_W  = ROW_W + 1;                // holds MAX_HEIGHT itself
    localparam int DEPTH   = MAX_WIDTH / 2;            // one entry per horizontal pair
    localparam int IDX_W   = $clog2(DEPTH);

    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } rmp_cfg_t;

    typedef logic [PIX_W-1:0] rmp_pix_t;

    // Where the current input pixel sits within the frame.
    typedef struct packed {
        logic             active;     // inside the even-sized part of the frame
        logic             odd_col;    // second pixel of a horizontal pair
        logic             lower_row;  // second row of a row pair
        logic             last;       // closes the last 2x2 block of the frame
        logic [IDX_W-1:0] idx;        // pair index along the line
    } rmp_pos_t;

    function automatic rmp_pix_t rgb_max(input rmp_pix_t a, input rmp_pix_t b);
        rmp_pix_t r;
        for (int c = 0; c < 3; c++) begin
            r[c*CH_W +: CH_W] = (a[c*CH_W +: CH_W] > b[c*CH_W +: CH_W]) ?
                                a[c*CH_W +: CH_W] : b[c*CH_W +: CH_W];
        end
        return r;
    endfunction

endpackage

// ===== src/rmp_line_ram.sv =====
// Line store for the horizontal pair maxima of the upper row of a row pair.
// Simple dual-port synchronous RAM with a registered read; uses rmp_pkg.
module rmp_line_ram (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [rmp_pkg::IDX_W-1:0] wr_addr,
    input  rmp_pkg::rmp_pix_t     wr_data,
    input  logic                  rd_en,
    input  logic [rmp_pkg::IDX_W-1:0] rd_addr,
    output rmp_pkg::rmp_pix_t     rd_data
);
    import rmp_pkg::*;

    rmp_pix_t mem [DEPTH];
    rmp_pix_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/rmp_scan.sv =====
// Frame geometry registers and the raster scan counters of the pooling core.
// Produces the position of the current pixel; uses rmp_pkg.
module rmp_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [rmp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rmp_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                          advance,
    output rmp_pkg::rmp_pos_t             pos
);
    import rmp_pkg::*;

    logic [WDIM_W-1:0] width_reg, width_next;
    logic [HDIM_W-1:0] height_reg, height_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    logic [WDIM_W-1:0] used_w;
    logic [HDIM_W-1:0] used_h;
    logic [WDIM_W-1:0] col_inc;
    logic [HDIM_W-1:0] row_inc;
    logic              cfg_hit;

    // Sizes are clamped when written, so the counters only see legal values.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        cfg_hit     = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:
                begin
                    cfg_hit = 1'b1;
                    if (cfg_data < SIZE_W'(MIN_SIZE))
                        width_next = WDIM_W'(MIN_SIZE);
                    else if (32'(cfg_data) > MAX_WIDTH)
                        width_next = WDIM_W'(MAX_WIDTH);
                    else
                        width_next = WDIM_W'(cfg_data);
                end
                CFG_FRAME_HEIGHT:
                begin
                    cfg_hit = 1'b1;
                    if (cfg_data < SIZE_W'(MIN_SIZE))
                        height_next = HDIM_W'(MIN_SIZE);
                    else if (32'(cfg_data) > MAX_HEIGHT)
                        height_next = HDIM_W'(MAX_HEIGHT);
                    else
                        height_next = HDIM_W'(cfg_data);
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    assign used_w  = {width_reg[WDIM_W-1:1], 1'b0};
    assign used_h  = {height_reg[HDIM_W-1:1], 1'b0};
    assign col_inc = {1'b0, col_reg} + WDIM_W'(1);
    assign row_inc = {1'b0, row_reg} + HDIM_W'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (advance)
        begin
            if (col_inc >= width_reg)
            begin
                col_next = '0;
                row_next = (row_inc >= height_reg) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WDIM_W'(640);
            height_reg <= HDIM_W'(480);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    assign pos.active    = ({1'b0, col_reg} < used_w) && ({1'b0, row_reg} < used_h);
    assign pos.odd_col   = col_reg[0];
    assign pos.lower_row = row_reg[0];
    assign pos.last      = (col_inc == used_w) && (row_inc == used_h);
    assign pos.idx       = col_reg[COL_W-1:1];

`ifndef SYNTHESIS
    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_reg} < width_reg)
        else $error("column counter left the frame");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, row_reg} < height_reg)
        else $error("row counter left the frame");

    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (col_reg == '0) && (row_reg == '0))
        else $error("register write did not restart the frame");
`endif

endmodule

// ===== src/rgb_max_pool_2x2_core.sv =====
//  channel | handshake                | payload
//  cfg     | cfg_valid / cfg_ready    | cfg_index (0 width, 1 height), cfg_data
//  pixel   | pix_valid / pix_ready    | red, green, blue
//  result  | res_valid / res_ready    | out_red, out_green, out_blue, out_alpha, frame_done
//
// One pixel word is taken per clock while pix_ready is high. A result word is registered
// from the pixel that closes its 2x2 block and is shown in the next cycle; the line store
// read for the block starts at the first pixel of the lower-row pair, so its delay is hidden.
// The result register is the only stall point: pix_ready drops only while it holds
// a word that is not taken. Reset gives width 640, height 480 and an empty pipeline.
// Configuration words are always taken; a write to either size register restarts the scan.
module rgb_max_pool_2x2_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rmp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rmp_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                          pix_valid,
    output logic                          pix_ready,
    input  logic [rmp_pkg::CH_W-1:0]      red,
    input  logic [rmp_pkg::CH_W-1:0]      green,
    input  logic [rmp_pkg::CH_W-1:0]      blue,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [rmp_pkg::CH_W-1:0]      out_red,
    output logic [rmp_pkg::CH_W-1:0]      out_green,
    output logic [rmp_pkg::CH_W-1:0]      out_blue,
    output logic [rmp_pkg::CH_W-1:0]      out_alpha,
    output logic                          frame_done
);
    import rmp_pkg::*;

    rmp_pos_t pos;
    rmp_pix_t pix;
    rmp_pix_t pair_max_reg, pair_max_next;
    rmp_pix_t pair_new;
    rmp_pix_t rd_data;
    rmp_pix_t block_max;
    rmp_pix_t res_pix_reg;
    logic     res_done_reg;
    logic     res_valid_reg, res_valid_next;
    logic     pix_fire;
    logic     rd_en, wr_en, gen;

    assign cfg_ready = 1'b1;
    assign pix_ready = !res_valid_reg || res_ready;
    assign pix_fire  = pix_valid && pix_ready;
    assign pix       = {red, green, blue};

    rmp_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (pix_fire),
        .pos       (pos)
    );

    // The upper row writes an entry and the lower row reads it back, so one
    // entry is never read and written in the same cycle.
    assign pair_new = rgb_max(pair_max_reg, pix);
    assign wr_en    = pix_fire && pos.active && !pos.lower_row && pos.odd_col;
    assign rd_en    = pix_fire && pos.active && pos.lower_row && !pos.odd_col;
    assign gen      = pix_fire && pos.active && pos.lower_row && pos.odd_col;

    rmp_line_ram u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pos.idx),
        .wr_data (pair_new),
        .rd_en   (rd_en),
        .rd_addr (pos.idx),
        .rd_data (rd_data)
    );

    assign block_max = rgb_max(rd_data, pair_new);

    always_comb
    begin
        pair_max_next = pair_max_reg;
        if (pix_fire && pos.active)
        begin
            pair_max_next = pos.odd_col ? pair_new : pix;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (gen)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_max_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pair_max_reg  <= pair_max_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen)
        begin
            res_pix_reg  <= block_max;
            res_done_reg <= pos.last;
        end
    end

    assign res_valid  = res_valid_reg;
    assign out_red    = res_pix_reg[2*CH_W +: CH_W];
    assign out_green  = res_pix_reg[CH_W +: CH_W];
    assign out_blue   = res_pix_reg[0 +: CH_W];
    assign out_alpha  = ALPHA_OPAQUE;
    assign frame_done = res_done_reg;

`ifndef SYNTHESIS
    a_no_ram_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("line store read and write in the same cycle");

    a_result_from_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(pix_fire))
        else $error("result word without an accepted pixel");

    a_read_before_use: assert property (@(posedge clk) disable iff (!rst_n)
        gen |-> !rd_en)
        else $error("block closed while its line store read is issued");
`endif

endmodule
